### src/tml_pkg.sv
// ----------------------------------------------------------------------------
// tml_pkg
// Shared constants, register codes and helpers of the triplet margin loss block.
// ----------------------------------------------------------------------------
`default_nettype none

package tml_pkg;

  localparam int FEATURE_WIDTH_DEF = 16;
  localparam int ACCUM_WIDTH_DEF   = 48;
  localparam int MAX_FEATURES_DEF  = 4096;

  localparam int DIST_W     = 32;
  localparam int EPS_W      = 16;
  localparam int MARGIN_W   = 32;
  localparam int DIV_W      = 16;
  localparam int DEG_W      = 4;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int LANES      = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NORM_DEGREE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR     = 3'd4;

  localparam logic [DEG_W-1:0]    NORM_DEGREE_RST = 4'd2;
  localparam logic [EPS_W-1:0]    EPSILON_RST     = 16'd0;
  localparam logic [MARGIN_W-1:0] MARGIN_RST      = 32'd65536;
  localparam logic [DIV_W-1:0]    DIVISOR_RST     = 16'd1;

  localparam logic [DEG_W-1:0] DEG_MIN = 4'd1;
  localparam logic [DEG_W-1:0] DEG_MAX = 4'd8;

  typedef struct packed {
    logic start;
    logic root;
  } lane_cmd_t;

  // degree zero acts as one, above eight acts as eight
  function automatic logic [DEG_W-1:0] eff_degree(input logic [DEG_W-1:0] d);
    logic [DEG_W-1:0] r;
    if (d == '0) begin
      r = DEG_MIN;
    end else if (d > DEG_MAX) begin
      r = DEG_MAX;
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/tml_pow.sv
// ----------------------------------------------------------------------------
// tml_pow
// Iterative Q16.16 power unit: r = t, then (p-1) times r = floor(r*t/2^16),
// saturating at the accumulator maximum. A multiply spans P_LO to P_SUM.
// ----------------------------------------------------------------------------
`default_nettype none

module tml_pow import tml_pkg::*; #(
  parameter int AccumWidth = ACCUM_WIDTH_DEF,
  parameter int TermWidth  = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DEG_W-1:0]      degree,
  input  wire logic [TermWidth-1:0]  term,
  output logic                       done,
  output logic [AccumWidth-1:0]      result
);

  localparam int HALF   = (AccumWidth + 1) / 2;
  localparam int UPPER  = AccumWidth - HALF;
  localparam int FULL_W = AccumWidth + TermWidth;
  localparam int Q_W    = FULL_W - FRAC_W;
  localparam int MW     = (AccumWidth > TermWidth) ? AccumWidth : TermWidth;

  typedef enum logic [3:0] {
    P_IDLE = 4'b0001,
    P_LO   = 4'b0010,
    P_HI   = 4'b0100,
    P_SUM  = 4'b1000
  } pow_state_t;

  pow_state_t              state_r, state_nxt;
  logic [2:0]              left_r, left_nxt;
  logic                    done_r, done_nxt;
  logic [AccumWidth-1:0]   r_r, r_nxt;
  logic [TermWidth-1:0]    t_r, t_nxt;
  logic [HALF+TermWidth-1:0]  pl_r, pl_nxt;
  logic [UPPER+TermWidth-1:0] ph_r, ph_nxt;

  logic [MW-1:0]         term_ext;
  logic [AccumWidth-1:0] term_sat;
  logic [FULL_W-1:0]     full;
  logic [Q_W-1:0]        quo;
  logic [AccumWidth-1:0] quo_sat;

  assign term_ext = MW'(term);
  assign term_sat = (term_ext > MW'({AccumWidth{1'b1}})) ? {AccumWidth{1'b1}}
                                                          : term_ext[AccumWidth-1:0];
  assign full     = (FULL_W'(ph_r) << HALF) + FULL_W'(pl_r);
  assign quo      = full[FULL_W-1:FRAC_W];
  assign quo_sat  = (|quo[Q_W-1:AccumWidth]) ? {AccumWidth{1'b1}} : quo[AccumWidth-1:0];

  always_comb begin
    state_nxt = state_r;
    left_nxt  = left_r;
    done_nxt  = 1'b0;
    r_nxt     = r_r;
    t_nxt     = t_r;
    pl_nxt    = pl_r;
    ph_nxt    = ph_r;
    unique case (state_r)
      P_IDLE: begin
        if (start) begin
          r_nxt    = term_sat;
          t_nxt    = term;
          left_nxt = 3'(degree - DEG_MIN);
          if (degree == DEG_MIN) begin
            done_nxt = 1'b1;
          end else begin
            state_nxt = P_LO;
          end
        end
      end
      P_LO: begin
        pl_nxt    = (HALF+TermWidth)'(r_r[HALF-1:0]) * (HALF+TermWidth)'(t_r);
        state_nxt = P_HI;
      end
      P_HI: begin
        ph_nxt    = (UPPER+TermWidth)'(r_r[AccumWidth-1:HALF]) * (UPPER+TermWidth)'(t_r);
        state_nxt = P_SUM;
      end
      P_SUM: begin
        r_nxt    = quo_sat;
        left_nxt = left_r - 3'd1;
        if (left_r == 3'd1) begin
          done_nxt  = 1'b1;
          state_nxt = P_IDLE;
        end else begin
          state_nxt = P_LO;
        end
      end
      default: state_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_IDLE;
      done_r  <= 1'b0;
      left_r  <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      left_r  <= left_nxt;
    end
    r_r  <= r_nxt;
    t_r  <= t_nxt;
    pl_r <= pl_nxt;
    ph_r <= ph_nxt;
  end

  assign done   = done_r;
  assign result = r_r;

endmodule

`default_nettype wire

### src/tml_lane.sv
// ----------------------------------------------------------------------------
// tml_lane
// One distance lane: power sum of (|x-y|+eps)^p and, at sample end,
// the floor p-th root of the sum found bit by bit with the same power unit.
// ----------------------------------------------------------------------------
`default_nettype none

module tml_lane import tml_pkg::*; #(
  parameter int FeatureWidth = FEATURE_WIDTH_DEF,
  parameter int AccumWidth   = ACCUM_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire lane_cmd_t                      cmd,
  input  wire logic signed [FeatureWidth-1:0] x_val,
  input  wire logic signed [FeatureWidth-1:0] y_val,
  input  wire logic [EPS_W-1:0]               epsilon,
  input  wire logic [DEG_W-1:0]               degree,
  output logic                                done,
  output logic [DIST_W-1:0]                   lane_dist
);

  localparam int TW = (FeatureWidth + 9 > DIST_W) ? FeatureWidth + 9 : DIST_W;

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_ACC  = 3'b010,
    L_ROOT = 3'b100
  } lane_state_t;

  lane_state_t           state_r, state_nxt;
  logic                  done_r, done_nxt;
  logic                  go_r, go_nxt;
  logic [TW-1:0]         t_r, t_nxt;
  logic [AccumWidth-1:0] sum_r, sum_nxt;
  logic [AccumWidth-1:0] lim_r, lim_nxt;
  logic [DIST_W-1:0]     dist_r, dist_nxt;
  logic [4:0]            bit_r, bit_nxt;

  logic signed [FeatureWidth:0] diff;
  logic [FeatureWidth-1:0]      mag;
  logic [TW-1:0]                term;
  logic [AccumWidth:0]          sum_add, lim_add;
  logic                         pow_done;
  logic [AccumWidth-1:0]        pow_res;
  logic [DIST_W-1:0]            keep;

  assign diff    = (FeatureWidth+1)'(x_val) - (FeatureWidth+1)'(y_val);
  assign mag     = diff[FeatureWidth] ? FeatureWidth'(-diff) : diff[FeatureWidth-1:0];
  assign term    = (TW'(mag) << 8) + TW'(epsilon);
  assign sum_add = (AccumWidth+1)'(sum_r) + (AccumWidth+1)'(pow_res);
  assign lim_add = (AccumWidth+1)'(sum_r) + (AccumWidth+1)'(epsilon);
  assign keep    = (pow_res <= lim_r) ? t_r[DIST_W-1:0] : dist_r;

  tml_pow #(
    .AccumWidth (AccumWidth),
    .TermWidth  (TW)
  ) u_pow (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (go_r),
    .degree (degree),
    .term   (t_r),
    .done   (pow_done),
    .result (pow_res)
  );

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    go_nxt    = 1'b0;
    t_nxt     = t_r;
    sum_nxt   = sum_r;
    lim_nxt   = lim_r;
    dist_nxt  = dist_r;
    bit_nxt   = bit_r;
    unique case (state_r)
      L_IDLE: begin
        if (cmd.start) begin
          go_nxt = 1'b1;
          if (cmd.root) begin
            lim_nxt   = lim_add[AccumWidth] ? {AccumWidth{1'b1}} : lim_add[AccumWidth-1:0];
            dist_nxt  = '0;
            bit_nxt   = 5'd31;
            t_nxt     = TW'({1'b1, {(DIST_W-1){1'b0}}});
            state_nxt = L_ROOT;
          end else begin
            t_nxt     = term;
            state_nxt = L_ACC;
          end
        end
      end
      L_ACC: begin
        if (pow_done) begin
          sum_nxt   = sum_add[AccumWidth] ? {AccumWidth{1'b1}} : sum_add[AccumWidth-1:0];
          done_nxt  = 1'b1;
          state_nxt = L_IDLE;
        end
      end
      L_ROOT: begin
        if (pow_done) begin
          dist_nxt = keep;
          if (bit_r == '0) begin
            sum_nxt   = '0;
            done_nxt  = 1'b1;
            state_nxt = L_IDLE;
          end else begin
            bit_nxt = bit_r - 5'd1;
            t_nxt   = TW'(keep | (DIST_W'(1) << (bit_r - 5'd1)));
            go_nxt  = 1'b1;
          end
        end
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
      go_r    <= 1'b0;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      go_r    <= go_nxt;
      sum_r   <= sum_nxt;
    end
    t_r    <= t_nxt;
    lim_r  <= lim_nxt;
    dist_r <= dist_nxt;
    bit_r  <= bit_nxt;
  end

  assign done      = done_r;
  assign lane_dist = dist_r;

endmodule

`default_nettype wire

### src/tml_merge.sv
// ----------------------------------------------------------------------------
// tml_merge
// Merges the three lane distances: optional swap, hinge with margin and a
// bit-serial restoring divide by the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module tml_merge import tml_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [DIST_W-1:0]   dist_ap,
  input  wire logic [DIST_W-1:0]   dist_an,
  input  wire logic [DIST_W-1:0]   dist_pn,
  input  wire logic [EPS_W-1:0]    epsilon,
  input  wire logic [MARGIN_W-1:0] margin,
  input  wire logic                swap_enable,
  input  wire logic [DIV_W-1:0]    divisor,
  output logic                     done,
  output logic [DIST_W-1:0]        loss
);

  localparam int DW = DIST_W + 2;   // dividend width
  localparam int HW = DIST_W + 3;   // signed hinge width

  typedef enum logic [1:0] {
    M_IDLE = 2'b01,
    M_DIV  = 2'b10
  } merge_state_t;

  merge_state_t      state_r, state_nxt;
  logic              done_r, done_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [DW-1:0]     dvd_r, dvd_nxt;
  logic [DIV_W:0]    rem_r, rem_nxt;
  logic [DIV_W-1:0]  div_r, div_nxt;

  logic [DIST_W:0]     ap, an, pn, an_sel;
  logic signed [HW-1:0] hinge;
  logic [DIV_W:0]      shifted;
  logic                ge;

  assign ap     = (DIST_W+1)'(dist_ap) + (DIST_W+1)'(epsilon);
  assign an     = (DIST_W+1)'(dist_an) + (DIST_W+1)'(epsilon);
  assign pn     = (DIST_W+1)'(dist_pn) + (DIST_W+1)'(epsilon);
  assign an_sel = (swap_enable && pn < an) ? pn : an;
  assign hinge  = $signed(HW'(ap)) - $signed(HW'(an_sel)) + $signed(HW'(margin));

  assign shifted = {rem_r[DIV_W-1:0], dvd_r[DW-1]};
  assign ge      = shifted >= {1'b0, div_r};

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    unique case (state_r)
      M_IDLE: begin
        if (start) begin
          dvd_nxt   = hinge[HW-1] ? '0 : hinge[DW-1:0];
          rem_nxt   = '0;
          div_nxt   = (divisor == '0) ? DIV_W'(1) : divisor;
          cnt_nxt   = 6'(DW - 1);
          state_nxt = M_DIV;
        end
      end
      M_DIV: begin
        rem_nxt = ge ? (shifted - {1'b0, div_r}) : shifted;
        dvd_nxt = {dvd_r[DW-2:0], ge};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = M_IDLE;
        end
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  // quotient saturates to 32 bits
  assign done = done_r;
  assign loss = (|dvd_r[DW-1:DIST_W]) ? {DIST_W{1'b1}} : dvd_r[DIST_W-1:0];

endmodule

`default_nettype wire

### src/triplet_margin_loss_forward_top.sv
// ----------------------------------------------------------------------------
// triplet_margin_loss_forward_top
// Fixed-point triplet margin loss with p-norm distances: three distance
// lanes accumulate per feature, then root, hinge and divide per sample.
// ----------------------------------------------------------------------------
//  channel | ports                                  | handshake
//  --------+----------------------------------------+-----------------
//  input   | in_*_value, in_last_feature            | in_valid/in_stall
//  result  | out_loss_value, out_dist_*             | out_valid/out_stall
//  config  | cfg_index, cfg_wdata                   | cfg_we
//
//  A feature beat is paced by the multiply of each lane's power unit, which
//  steps through P_LO, P_HI and P_SUM. Closing a sample adds the bit-serial
//  root and the divide in the merge stage.
//  rst_n is synchronous; it clears control state and loads register defaults.
//  A finished result waits in the output register while new beats are taken;
//  the next result waits until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module triplet_margin_loss_forward_top import tml_pkg::*; #(
  parameter int FeatureWidth = FEATURE_WIDTH_DEF,
  parameter int AccumWidth   = ACCUM_WIDTH_DEF,
  parameter int MaxFeatures  = MAX_FEATURES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [CFG_IDX_W-1:0]           cfg_index,
  input  wire logic [CFG_DATA_W-1:0]          cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [FeatureWidth-1:0] in_anchor_value,
  input  wire logic signed [FeatureWidth-1:0] in_positive_value,
  input  wire logic signed [FeatureWidth-1:0] in_negative_value,
  input  wire logic                           in_last_feature,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [DIST_W-1:0]                   out_loss_value,
  output logic [DIST_W-1:0]                   out_dist_anchor_positive,
  output logic [DIST_W-1:0]                   out_dist_anchor_negative,
  output logic [DIST_W-1:0]                   out_dist_positive_negative
);

  localparam int CW = (MaxFeatures > 1) ? $clog2(MaxFeatures) : 1;

  typedef enum logic [4:0] {
    T_IDLE  = 5'b00001,
    T_ACC   = 5'b00010,
    T_ROOT  = 5'b00100,
    T_MERGE = 5'b01000,
    T_WAIT  = 5'b10000
  } top_state_t;

  top_state_t            state_r, state_nxt;
  logic [DEG_W-1:0]      degree_r;
  logic [EPS_W-1:0]      eps_r;
  logic [MARGIN_W-1:0]   margin_r;
  logic                  swap_r;
  logic [DIV_W-1:0]      divisor_r;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  close_r, close_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0]     loss_r, loss_nxt;
  logic [DIST_W-1:0]     oloss_r, oap_r, oan_r, opn_r;
  lane_cmd_t             cmd;
  logic                  merge_go;

  logic                  in_fire;
  logic                  slot_free;
  logic [DEG_W-1:0]      degree;
  logic [LANES-1:0]      lane_done;
  logic [DIST_W-1:0]     dist_ap, dist_an, dist_pn;
  logic                  merge_done;
  logic [DIST_W-1:0]     merge_loss;

  assign degree    = eff_degree(degree_r);
  assign in_stall  = (state_r != T_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r  <= NORM_DEGREE_RST;
      eps_r     <= EPSILON_RST;
      margin_r  <= MARGIN_RST;
      swap_r    <= 1'b0;
      divisor_r <= DIVISOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NORM_DEGREE: degree_r  <= cfg_wdata[DEG_W-1:0];
        REG_EPSILON:     eps_r     <= cfg_wdata[EPS_W-1:0];
        REG_MARGIN:      margin_r  <= cfg_wdata[MARGIN_W-1:0];
        REG_SWAP_ENABLE: swap_r    <= cfg_wdata[0];
        REG_DIVISOR:     divisor_r <= cfg_wdata[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  tml_lane #(.FeatureWidth(FeatureWidth), .AccumWidth(AccumWidth)) u_lane_ap (
    .clk (clk), .rst_n (rst_n), .cmd (cmd),
    .x_val (in_anchor_value), .y_val (in_positive_value),
    .epsilon (eps_r), .degree (degree),
    .done (lane_done[0]), .lane_dist (dist_ap)
  );

  tml_lane #(.FeatureWidth(FeatureWidth), .AccumWidth(AccumWidth)) u_lane_an (
    .clk (clk), .rst_n (rst_n), .cmd (cmd),
    .x_val (in_anchor_value), .y_val (in_negative_value),
    .epsilon (eps_r), .degree (degree),
    .done (lane_done[1]), .lane_dist (dist_an)
  );

  tml_lane #(.FeatureWidth(FeatureWidth), .AccumWidth(AccumWidth)) u_lane_pn (
    .clk (clk), .rst_n (rst_n), .cmd (cmd),
    .x_val (in_positive_value), .y_val (in_negative_value),
    .epsilon (eps_r), .degree (degree),
    .done (lane_done[2]), .lane_dist (dist_pn)
  );

  tml_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (merge_go),
    .dist_ap     (dist_ap),
    .dist_an     (dist_an),
    .dist_pn     (dist_pn),
    .epsilon     (eps_r),
    .margin      (margin_r),
    .swap_enable (swap_r),
    .divisor     (divisor_r),
    .done        (merge_done),
    .loss        (merge_loss)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    close_nxt     = close_r;
    loss_nxt      = loss_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '{start: 1'b0, root: 1'b0};
    merge_go      = 1'b0;
    unique case (state_r)
      T_IDLE: begin
        if (in_fire) begin
          cmd       = '{start: 1'b1, root: 1'b0};
          close_nxt = in_last_feature || (cnt_r == CW'(MaxFeatures - 1));
          state_nxt = T_ACC;
        end
      end
      T_ACC: begin
        if (&lane_done) begin
          if (close_r) begin
            cmd       = '{start: 1'b1, root: 1'b1};
            cnt_nxt   = '0;
            state_nxt = T_ROOT;
          end else begin
            cnt_nxt   = cnt_r + CW'(1);
            state_nxt = T_IDLE;
          end
        end
      end
      T_ROOT: begin
        if (&lane_done) begin
          merge_go  = 1'b1;
          state_nxt = T_MERGE;
        end
      end
      T_MERGE: begin
        if (merge_done) begin
          loss_nxt  = merge_loss;
          state_nxt = T_WAIT;
        end
      end
      T_WAIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      cnt_r       <= '0;
      close_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      close_r     <= close_nxt;
      out_valid_r <= out_valid_nxt;
    end
    loss_r <= loss_nxt;
    // output beat loads when the sample leaves the wait state
    if (state_r == T_WAIT && slot_free) begin
      oloss_r <= loss_r;
      oap_r   <= dist_ap;
      oan_r   <= dist_an;
      opn_r   <= dist_pn;
    end
  end

  assign out_valid                  = out_valid_r;
  assign out_loss_value             = oloss_r;
  assign out_dist_anchor_positive   = oap_r;
  assign out_dist_anchor_negative   = oan_r;
  assign out_dist_positive_negative = opn_r;

  // lanes run in lockstep
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (|lane_done) |-> (&lane_done))
    else $error("distance lanes finished out of step");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MaxFeatures - 1))
    else $error("feature counter past sample limit");

  a_fire_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == T_ACC))
    else $error("accepted beat did not start accumulation");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r && $stable(oloss_r))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
